@@ hdl/request_frame_receiver_defines.svh @@
// Assertion macros for the request frame receiver
`ifndef REQUEST_FRAME_RECEIVER_DEFINES_SVH
`define REQUEST_FRAME_RECEIVER_DEFINES_SVH

// a implies b on the next edge
`define RFR_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

// a implies b on the same edge
`define RFR_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`endif

@@ hdl/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rfr_pkg
// Types and constants shared by the request frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rfr_pkg;
    localparam int PAYLOAD_MAX_DEF  = 20;
    localparam int BUFFER_BYTES_DEF = 26;

    localparam logic [15:0] CH_COMMAND = 16'h0100;
    localparam logic [15:0] CH_STATE   = 16'h0101;
    localparam logic [15:0] CH_MOTION  = 16'h0102;
    localparam logic [15:0] CH_ANALOG  = 16'h0120;

    localparam logic [2:0] REG_START       = 3'd0;
    localparam logic [2:0] REG_READ        = 3'd1;
    localparam logic [2:0] REG_WRITE       = 3'd2;
    localparam logic [2:0] REG_WRITE_REPLY = 3'd3;
    localparam logic [2:0] REG_HIGHEST     = 3'd4;

    localparam logic [2:0] EV_CONNECT = 3'd0;
    localparam logic [2:0] EV_STATE   = 3'd1;
    localparam logic [2:0] EV_MOTION  = 3'd2;
    localparam logic [2:0] EV_ANALOG  = 3'd3;
    localparam logic [2:0] EV_CMD     = 3'd4;
    localparam logic [2:0] EV_EMPTY   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,    // wait for a byte
        ST_SCAN,    // issue read of the byte at scan position
        ST_WAIT,    // RAM read latency
        ST_EVAL,    // examine read byte
        ST_SUM,     // issue read of the next payload or checksum byte
        ST_EMIT,    // issue read of payload byte
        ST_EMITW,   // RAM read latency
        ST_LOAD,    // capture payload result
        ST_OUT,     // hold result until taken
        ST_DROP     // advance frame start
    } state_t;

    // command to the datapath
    typedef struct packed {
        logic wr_byte;     // append incoming byte
        logic set_pos;     // pos <= base + offset chosen by off_sel
        logic [1:0] off_sel; // 0: index, 1: index plus five (payload), 2: one
        logic inc_idx;
        logic clr_idx;
        logic drop;        // base++
        logic empty;       // count cleared, base moved to head
        logic clr_sum;
        logic add_sum;
        logic load_field;  // store read byte at idx field slot
        logic load_out;
        logic [2:0] out_ev;
        logic out_last;
        logic bump_pin;
    } cmd_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic [8:0] avail;   // bytes from base onward
        logic [8:0] idx;
        logic [7:0] code;
        logic [15:0] ch;
        logic [7:0] len;
        logic sum_ok;
    } stat_t;
endpackage
`default_nettype wire

@@ hdl/request_frame_receiver.sv @@
// A read result is registered once the scan has checked the byte that completes a frame
// at the buffer head; each byte takes a read, a RAM latency state and an evaluate state.
// Each command payload result is then read, loaded and held until the output is not stalled.
// Input stalls until the scan ends; a rescan after a reject restarts at the new frame
// start and may walk every byte still buffered.
// Reset: asynchronous active-low; buffer empty, pin 0, registers at defaults.
// ----------------------------------------------------------------------------
// request_frame_receiver
// Byte-serial request frame parser with configurable codes.
// ----------------------------------------------------------------------------
`default_nettype none
module request_frame_receiver #(
    parameter int PAYLOAD_MAX  = rfr_pkg::PAYLOAD_MAX_DEF,
    parameter int BUFFER_BYTES = rfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      event_res,
    output logic [1:0]      analog_pin,
    output logic [7:0]      payload_byte,
    output logic            reply_wanted,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    logic [7:0] start_reg, read_reg, write_reg, write_reply_reg, highest_reg;
    rfr_pkg::cmd_t  cmd;
    rfr_pkg::stat_t stat;
    logic reply;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg       <= 8'd0;
            read_reg        <= 8'd0;
            write_reg       <= 8'd1;
            write_reply_reg <= 8'd2;
            highest_reg     <= 8'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rfr_pkg::REG_START:       start_reg       <= cfg_data;
                rfr_pkg::REG_READ:        read_reg        <= cfg_data;
                rfr_pkg::REG_WRITE:       write_reg       <= cfg_data;
                rfr_pkg::REG_WRITE_REPLY: write_reply_reg <= cfg_data;
                rfr_pkg::REG_HIGHEST:     highest_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    rfr_ctrl #(.PAYLOAD_MAX(PAYLOAD_MAX), .BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .start_byte(start_reg), .read_code(read_reg), .write_code(write_reg),
        .write_reply_code(write_reply_reg), .highest_code(highest_reg),
        .stat(stat), .cmd(cmd), .reply(reply)
    );

    rfr_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .rx_byte(rx_byte),
        .reply_in(reply), .event_res(event_res), .analog_pin(analog_pin),
        .payload_byte(payload_byte), .reply_wanted(reply_wanted), .last(last)
    );
endmodule
`default_nettype wire

@@ hdl/rfr_ram.sv @@
// ----------------------------------------------------------------------------
// rfr_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 26
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/rfr_datapath.sv @@
// ----------------------------------------------------------------------------
// rfr_datapath
// Byte buffer, scan pointers, field capture, checksum and result register.
// The buffer is a circular window: base marks the frame start, count the fill.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_datapath #(
    parameter int BUFFER_BYTES = rfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rfr_pkg::cmd_t cmd,
    output rfr_pkg::stat_t     stat,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          reply_in,
    output logic [2:0]         event_res,
    output logic [1:0]         analog_pin,
    output logic [7:0]         payload_byte,
    output logic               reply_wanted,
    output logic               last
);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [AW-1:0] base_reg, head_reg, pos_reg;
    logic [8:0]    avail_reg, idx_reg;
    logic [7:0]    code_reg, chh_reg, chl_reg, len_reg;
    logic [8:0]    sum_reg;
    logic [1:0]    pin_reg;
    logic [7:0]    rd;
    logic [AW:0]   padd;
    logic [AW-1:0] pos_next;
    logic [8:0]    sum_add;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        if (v >= (AW+1)'(BUFFER_BYTES))
            return AW'(v - (AW+1)'(BUFFER_BYTES));
        return AW'(v);
    endfunction

    rfr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
        .clk(clk), .we(cmd.wr_byte), .waddr(head_reg), .wdata(rx_byte),
        .raddr(pos_reg), .rdata(rd)
    );

    always_comb
    begin
        case (cmd.off_sel)
            2'd0:    padd = {1'b0, base_reg} + (AW+1)'(idx_reg);
            // payload bytes start after the five header bytes
            2'd1:    padd = {1'b0, base_reg} + (AW+1)'(idx_reg) + (AW+1)'(5);
            default: padd = {1'b0, base_reg} + (AW+1)'(1);
        endcase
        pos_next = wrap(padd);
        // mod 255 kept below 255 by one compare and subtract
        sum_add = sum_reg + {1'b0, rd};
        if (sum_add >= 9'd255)
            sum_add = sum_add - 9'd255;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            head_reg  <= '0;
            pos_reg   <= '0;
            avail_reg <= '0;
            idx_reg   <= '0;
            pin_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cmd.wr_byte)
            begin
                head_reg  <= wrap({1'b0, head_reg} + (AW+1)'(1));
                avail_reg <= avail_reg + 9'd1;
            end
            if (cmd.empty)
            begin
                base_reg  <= head_reg;
                avail_reg <= '0;
            end
            else if (cmd.drop)
            begin
                base_reg  <= wrap({1'b0, base_reg} + (AW+1)'(1));
                avail_reg <= avail_reg - 9'd1;
            end
            if (cmd.set_pos)
                pos_reg <= pos_next;
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + 9'd1;
            if (cmd.clr_sum)
                sum_reg <= '0;
            else if (cmd.add_sum)
                sum_reg <= sum_add;
            if (cmd.bump_pin)
                pin_reg <= pin_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_field)
        begin
            case (idx_reg)
                9'd1:    code_reg <= rd;
                9'd2:    chh_reg  <= rd;
                9'd3:    chl_reg  <= rd;
                9'd4:    len_reg  <= rd;
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            event_res    <= cmd.out_ev;
            analog_pin   <= (cmd.out_ev == rfr_pkg::EV_ANALOG) ? pin_reg : 2'd0;
            payload_byte <= (cmd.out_ev == rfr_pkg::EV_CMD) ? rd : 8'd0;
            reply_wanted <= (cmd.out_ev == rfr_pkg::EV_CMD ||
                             cmd.out_ev == rfr_pkg::EV_EMPTY) ? reply_in : 1'b0;
            last         <= cmd.out_last;
        end
    end

    assign stat.rd_byte = rd;
    assign stat.avail   = avail_reg;
    assign stat.idx     = idx_reg;
    assign stat.code    = code_reg;
    assign stat.ch      = {chh_reg, chl_reg};
    assign stat.len     = len_reg;
    assign stat.sum_ok  = (sum_reg[7:0] == rd);
endmodule
`default_nettype wire

@@ hdl/rfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfr_ctrl
// Scan controller: walks the buffer one byte at a time (read, wait, evaluate),
// decides accept or drop, and sequences the result requests.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_ctrl #(
    parameter int PAYLOAD_MAX  = rfr_pkg::PAYLOAD_MAX_DEF,
    parameter int BUFFER_BYTES = rfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire logic [7:0]     start_byte,
    input  wire logic [7:0]     read_code,
    input  wire logic [7:0]     write_code,
    input  wire logic [7:0]     write_reply_code,
    input  wire logic [7:0]     highest_code,
    input  wire rfr_pkg::stat_t stat,
    output rfr_pkg::cmd_t       cmd,
    output logic                reply
);
    rfr_pkg::state_t state_reg, state_next;
    logic       last_out_reg, last_out_next;
    logic       is_read, is_write, accept_byte;
    logic [2:0] read_ev;
    logic       read_hit;
    logic [8:0] size;
    logic [15:0] ch_now;
    logic [7:0]  len_now;

    always_comb
    begin
        // the field being examined is still on the RAM output, not yet captured
        ch_now   = (stat.idx == 9'd3) ? {stat.ch[15:8], stat.rd_byte} : stat.ch;
        len_now  = (stat.idx == 9'd4) ? stat.rd_byte : stat.len;
        is_read  = (stat.code == read_code);
        is_write = !is_read && ch_now == rfr_pkg::CH_COMMAND &&
                   (stat.code == write_code || stat.code == write_reply_code);
        reply    = (stat.code == write_reply_code);
        read_hit = 1'b1;
        read_ev  = rfr_pkg::EV_CONNECT;
        case (ch_now)
            rfr_pkg::CH_COMMAND: read_ev = rfr_pkg::EV_CONNECT;
            rfr_pkg::CH_STATE:   read_ev = rfr_pkg::EV_STATE;
            rfr_pkg::CH_MOTION:  read_ev = rfr_pkg::EV_MOTION;
            rfr_pkg::CH_ANALOG:  read_ev = rfr_pkg::EV_ANALOG;
            default:             read_hit = 1'b0;
        endcase
        size = {1'b0, len_now} + 9'd6;
    end

    assign accept_byte = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rfr_pkg::ST_IDLE;
            last_out_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_out_reg <= last_out_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        last_out_next = last_out_reg;
        case (state_reg)
            rfr_pkg::ST_IDLE:
                if (accept_byte)
                    state_next = rfr_pkg::ST_SCAN;
            rfr_pkg::ST_SCAN:
                if (stat.idx >= stat.avail)
                    state_next = rfr_pkg::ST_IDLE;
                else
                    state_next = rfr_pkg::ST_WAIT;
            rfr_pkg::ST_WAIT:
                state_next = rfr_pkg::ST_EVAL;
            rfr_pkg::ST_EVAL:
            begin
                state_next = rfr_pkg::ST_SCAN;
                case (stat.idx)
                    9'd0:
                        if (stat.rd_byte != start_byte)
                            state_next = rfr_pkg::ST_DROP;
                    9'd1:
                        if (stat.rd_byte > highest_code)
                            state_next = rfr_pkg::ST_DROP;
                    9'd2: ;
                    9'd3:
                        if (is_read && read_hit)
                        begin
                            state_next    = rfr_pkg::ST_OUT;
                            last_out_next = 1'b1;
                        end
                        else if (!is_write)
                            state_next = rfr_pkg::ST_DROP;
                    9'd4:
                        if (len_now > 8'(PAYLOAD_MAX) ||
                            size > 9'(BUFFER_BYTES))
                            state_next = rfr_pkg::ST_DROP;
                        else if (stat.avail < size)
                            state_next = rfr_pkg::ST_IDLE;
                        else
                            state_next = rfr_pkg::ST_SUM;
                    default:
                    begin
                        // payload bytes keep summing; checksum byte at idx == len + 5
                        if (stat.idx < 9'({1'b0, stat.len}) + 9'd5)
                            state_next = rfr_pkg::ST_SUM;
                        else if (!stat.sum_ok || stat.rd_byte == 8'hFF)
                            state_next = rfr_pkg::ST_DROP;
                        else if (stat.len == 8'd0)
                        begin
                            state_next    = rfr_pkg::ST_OUT;
                            last_out_next = 1'b1;
                        end
                        else
                            state_next = rfr_pkg::ST_EMIT;
                    end
                endcase
            end
            rfr_pkg::ST_SUM:
                // idx walks 5 .. len+5, summing until the checksum byte
                state_next = rfr_pkg::ST_WAIT;
            rfr_pkg::ST_EMIT:
                state_next = rfr_pkg::ST_EMITW;
            rfr_pkg::ST_EMITW:
                state_next = rfr_pkg::ST_LOAD;
            rfr_pkg::ST_LOAD:
            begin
                state_next    = rfr_pkg::ST_OUT;
                last_out_next = (stat.idx + 9'd1 == {1'b0, stat.len});
            end
            rfr_pkg::ST_OUT:
                if (!out_stall)
                begin
                    if (last_out_reg)
                        state_next = rfr_pkg::ST_IDLE;
                    else
                        state_next = rfr_pkg::ST_EMIT;
                end
            rfr_pkg::ST_DROP:
                state_next = rfr_pkg::ST_SCAN;
            default:
                state_next = rfr_pkg::ST_IDLE;
        endcase
    end

    // outputs / datapath requests
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            rfr_pkg::ST_IDLE:
            begin
                in_stall = (stat.avail >= 9'(BUFFER_BYTES));
                // full buffer cannot occur; still accept and rescan
                if (in_valid && stat.avail >= 9'(BUFFER_BYTES))
                    in_stall = 1'b0;
                cmd.wr_byte = in_valid && stat.avail < 9'(BUFFER_BYTES);
                cmd.clr_idx = 1'b1;
                cmd.set_pos = 1'b1;
                cmd.off_sel = 2'd2; // unused until SCAN resets it
            end
            rfr_pkg::ST_SCAN:
            begin
                cmd.set_pos = 1'b1;
                cmd.off_sel = 2'd0;
                if (stat.idx == 9'd0)
                    cmd.clr_sum = 1'b1;
            end
            rfr_pkg::ST_EVAL:
            begin
                cmd.load_field = 1'b1;
                cmd.inc_idx    = 1'b1;
                if (stat.idx < 9'd4 || (stat.idx == 9'd4))
                    cmd.add_sum = 1'b1;
                case (stat.idx)
                    9'd0:
                        if (stat.rd_byte != start_byte)
                            cmd.inc_idx = 1'b0;
                    9'd1: ;
                    9'd2: ;
                    9'd3:
                        if (is_read && read_hit)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_ev   = read_ev;
                            cmd.out_last = 1'b1;
                            cmd.bump_pin = (read_ev == rfr_pkg::EV_ANALOG);
                        end
                    9'd4: ;
                    default:
                        if (stat.idx == 9'({1'b0, stat.len}) + 9'd5 &&
                            stat.sum_ok && stat.rd_byte != 8'hFF)
                        begin
                            if (stat.len == 8'd0)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.out_ev   = rfr_pkg::EV_EMPTY;
                                cmd.out_last = 1'b1;
                            end
                            else
                            begin
                                cmd.clr_idx = 1'b1; // reuse idx for payload walk
                                cmd.inc_idx = 1'b0;
                            end
                        end
                endcase
                if (stat.idx > 9'd4 && stat.idx < 9'({1'b0, stat.len}) + 9'd5)
                    cmd.add_sum = 1'b1;
            end
            rfr_pkg::ST_SUM:
            begin
                cmd.set_pos = 1'b1;
                cmd.off_sel = 2'd0;
            end
            rfr_pkg::ST_EMIT:
            begin
                cmd.set_pos = 1'b1;
                cmd.off_sel = 2'd1;
            end
            rfr_pkg::ST_LOAD:
            begin
                cmd.load_out = 1'b1;
                cmd.out_ev   = rfr_pkg::EV_CMD;
                cmd.out_last = (stat.idx + 9'd1 == {1'b0, stat.len});
            end
            rfr_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.inc_idx = 1'b1;
                    if (last_out_reg)
                        cmd.empty = 1'b1;
                end
            end
            rfr_pkg::ST_DROP:
            begin
                cmd.drop    = 1'b1;
                cmd.clr_idx = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/rfr_checker.sv @@
// ----------------------------------------------------------------------------
// rfr_checker
// Port-level checks on the request frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "request_frame_receiver_defines.svh"
module rfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] event_res,
    input wire logic [1:0] analog_pin,
    input wire logic [7:0] payload_byte,
    input wire logic       reply_wanted,
    input wire logic       last
);
    `RFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(event_res), "result dropped while stalled")
    `RFR_ASSERT_NOW(a_ev_range, clk, rst_n, out_valid, event_res <= 3'd5, "bad event code")
    `RFR_ASSERT_NOW(a_read_last, clk, rst_n, out_valid && event_res < 3'd4, last && !reply_wanted && payload_byte == 8'd0, "read event fields wrong")
    `RFR_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, in_stall, "input taken during result")
endmodule

bind request_frame_receiver rfr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
    .analog_pin(analog_pin), .payload_byte(payload_byte),
    .reply_wanted(reply_wanted), .last(last)
);
`default_nettype wire

@@ verif/request_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_frame_receiver_tb
// Sends received bytes to the frame parser and checks each event against
// a behavioral parser that runs alongside. A short directed table comes
// first, then random frames mixed with noise under several code settings.
// ----------------------------------------------------------------------------
module request_frame_receiver_tb;
    typedef struct {
        logic [2:0] ev;
        logic [1:0] pin;
        logic [7:0] pay;
        logic       rep;
        logic       lst;
    } event_t;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        event_t     want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_res;
    logic [1:0] analog_pin;
    logic [7:0] payload_byte;
    logic       reply_wanted;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = rfr_pkg::REG_START;
    logic [7:0] cfg_data = 8'h00;

    // parser copy: held bytes, pin counter, code registers
    logic [7:0] held_bytes[$];
    logic [1:0] pin_next;
    logic [7:0] code_reg[5];
    event_t     fresh_events[$];
    event_t     pending_events[$];
    int         errors = 0;
    bit         calm = 1'b0;

    request_frame_receiver u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .analog_pin(analog_pin), .payload_byte(payload_byte),
        .reply_wanted(reply_wanted), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic event_t mk_event(logic [2:0] ev, logic [1:0] pin, logic [7:0] pay,
                                        logic rep, logic lst);
        event_t e;
        e.ev = ev; e.pin = pin; e.pay = pay; e.rep = rep; e.lst = lst;
        return e;
    endfunction

    // append one byte and rescan; events land in fresh_events
    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] code;
        logic [15:0] chan;
        int len;
        int sum;
        bit reply;
        bit found;
        logic [2:0] ev;
        logic [1:0] pin;
        fresh_events.delete();
        if (held_bytes.size() < rfr_pkg::BUFFER_BYTES_DEF)
            held_bytes.push_back(b);
        forever
        begin
            while (held_bytes.size() > 0 && held_bytes[0] != code_reg[rfr_pkg::REG_START])
                void'(held_bytes.pop_front());
            if (held_bytes.size() < 2)
                return;
            code = held_bytes[1];
            if (code > code_reg[rfr_pkg::REG_HIGHEST])
            begin
                void'(held_bytes.pop_front());
                continue;
            end
            if (held_bytes.size() < 4)
                return;
            chan = {held_bytes[2], held_bytes[3]};
            if (code == code_reg[rfr_pkg::REG_READ])
            begin
                found = 1'b1;
                pin = 2'd0;
                if (chan == rfr_pkg::CH_COMMAND) ev = rfr_pkg::EV_CONNECT;
                else if (chan == rfr_pkg::CH_STATE) ev = rfr_pkg::EV_STATE;
                else if (chan == rfr_pkg::CH_MOTION) ev = rfr_pkg::EV_MOTION;
                else if (chan == rfr_pkg::CH_ANALOG)
                begin
                    ev = rfr_pkg::EV_ANALOG;
                    pin = pin_next;
                    pin_next = pin_next + 2'd1;
                end
                else found = 1'b0;
                if (found)
                begin
                    fresh_events.push_back(mk_event(ev, pin, 8'h00, 1'b0, 1'b1));
                    held_bytes.delete();
                    return;
                end
            end
            else if (chan == rfr_pkg::CH_COMMAND &&
                     (code == code_reg[rfr_pkg::REG_WRITE] ||
                      code == code_reg[rfr_pkg::REG_WRITE_REPLY]))
            begin
                reply = (code == code_reg[rfr_pkg::REG_WRITE_REPLY]);
                if (held_bytes.size() < 5)
                    return;
                len = held_bytes[4];
                if (len > rfr_pkg::PAYLOAD_MAX_DEF || len + 6 > rfr_pkg::BUFFER_BYTES_DEF)
                begin
                    void'(held_bytes.pop_front());
                    continue;
                end
                if (held_bytes.size() < len + 6)
                    return;
                sum = 0;
                for (int i = 0; i < len + 5; i++)
                    sum += held_bytes[i];
                if (sum % 255 != held_bytes[len + 5])
                begin
                    void'(held_bytes.pop_front());
                    continue;
                end
                if (len == 0)
                    fresh_events.push_back(mk_event(rfr_pkg::EV_EMPTY, 2'd0, 8'h00,
                                                    reply, 1'b1));
                else
                    for (int i = 0; i < len; i++)
                        fresh_events.push_back(mk_event(rfr_pkg::EV_CMD, 2'd0,
                                                        held_bytes[5 + i], reply,
                                                        i + 1 == len));
                held_bytes.delete();
                return;
            end
            void'(held_bytes.pop_front());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input event_t want);
        if (!calm && $urandom_range(3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(18, 1) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (in_stall);
        parse_byte(b);
        if (typed)
            pending_events.push_back(want);
        else
            foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        // a dropped frame may still be rescanning
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_codes(input logic [7:0] s, input logic [7:0] rd, input logic [7:0] wr,
                               input logic [7:0] wrr, input logic [7:0] hi);
        logic [7:0] vals[5];
        vals = '{s, rd, wr, wrr, hi};
        for (int i = 0; i < 5; i++)
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = 3'(i);
            cfg_data = vals[i];
            do @(posedge clk); while (!cfg_ready);
            code_reg[i] = vals[i];
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one random frame, sometimes with noise or a broken part
    task automatic send_frame();
        logic [7:0] frame[$];
        logic [7:0] code;
        event_t none;
        int len;
        int sum;
        int pick;
        none = mk_event(3'd0, 2'd0, 8'h00, 1'b0, 1'b0);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(3, 1)) frame.push_back(8'($urandom));
        frame.push_back(code_reg[rfr_pkg::REG_START]);
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            frame.push_back(code_reg[rfr_pkg::REG_READ]);
            case ($urandom_range(4))
                0:
                begin
                    frame.push_back(rfr_pkg::CH_COMMAND[15:8]);
                    frame.push_back(rfr_pkg::CH_COMMAND[7:0]);
                end
                1:
                begin
                    frame.push_back(rfr_pkg::CH_STATE[15:8]);
                    frame.push_back(rfr_pkg::CH_STATE[7:0]);
                end
                2:
                begin
                    frame.push_back(rfr_pkg::CH_MOTION[15:8]);
                    frame.push_back(rfr_pkg::CH_MOTION[7:0]);
                end
                3:
                begin
                    frame.push_back(rfr_pkg::CH_ANALOG[15:8]);
                    frame.push_back(rfr_pkg::CH_ANALOG[7:0]);
                end
                default:
                begin
                    frame.push_back(8'($urandom));
                    frame.push_back(8'($urandom));
                end
            endcase
        end
        else if (pick < 9)
        begin
            code = $urandom_range(1) ? code_reg[rfr_pkg::REG_WRITE]
                                     : code_reg[rfr_pkg::REG_WRITE_REPLY];
            frame.push_back(code);
            frame.push_back(rfr_pkg::CH_COMMAND[15:8]);
            frame.push_back(rfr_pkg::CH_COMMAND[7:0]);
            case ($urandom_range(9))
                0: len = 0;
                1: len = rfr_pkg::PAYLOAD_MAX_DEF;
                2: len = $urandom_range(255, rfr_pkg::PAYLOAD_MAX_DEF + 1);
                default: len = $urandom_range(4, 1);
            endcase
            frame.push_back(8'(len));
            if (len <= rfr_pkg::PAYLOAD_MAX_DEF)
            begin
                repeat (len) frame.push_back(8'($urandom));
                sum = 0;
                foreach (frame[i])
                    if (i >= frame.size() - len - 5) sum += frame[i];
                case ($urandom_range(7))
                    0: frame.push_back(8'hFF);
                    1: frame.push_back(8'($urandom));
                    default: frame.push_back(8'(sum % 255));
                endcase
            end
        end
        else
        begin
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
        end
        foreach (frame[i]) send_byte(frame[i], 1'b0, none);
    endtask

    // receiver stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (calm)
                out_stall = 1'b0;
            else
            begin
                out_stall = $urandom_range(1);
                repeat ($urandom_range(18, 1) - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        event_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
                report($sformatf("unexpected event %0d", event_res));
            else
            begin
                e = pending_events.pop_front();
                if (event_res !== e.ev)
                    report($sformatf("event %0d, wanted %0d", event_res, e.ev));
                if (analog_pin !== e.pin)
                    report($sformatf("pin %0d, wanted %0d", analog_pin, e.pin));
                if (payload_byte !== e.pay)
                    report($sformatf("payload %h, wanted %h", payload_byte, e.pay));
                if (reply_wanted !== e.rep)
                    report($sformatf("reply flag %b, wanted %b", reply_wanted, e.rep));
                if (last !== e.lst)
                    report($sformatf("last %b, wanted %b", last, e.lst));
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        event_t none;
        none = mk_event(3'd0, 2'd0, 8'h00, 1'b0, 1'b0);
        held_bytes.delete();
        pin_next = 2'd0;
        code_reg = '{8'd0, 8'd0, 8'd1, 8'd2, 8'd3};
        // default codes: start 00, read 00, write 01, write with reply 02
        rows = '{
            '{8'h00, 0, none}, '{8'h00, 0, none}, '{8'h01, 0, none},
            '{8'h00, 1, mk_event(rfr_pkg::EV_CONNECT, 2'd0, 8'h00, 1'b0, 1'b1)},
            '{8'h00, 0, none}, '{8'h00, 0, none}, '{8'h01, 0, none},
            '{8'h01, 1, mk_event(rfr_pkg::EV_STATE, 2'd0, 8'h00, 1'b0, 1'b1)},
            '{8'h00, 0, none}, '{8'h00, 0, none}, '{8'h01, 0, none},
            '{8'h02, 1, mk_event(rfr_pkg::EV_MOTION, 2'd0, 8'h00, 1'b0, 1'b1)},
            '{8'h00, 0, none}, '{8'h00, 0, none}, '{8'h01, 0, none},
            '{8'h20, 1, mk_event(rfr_pkg::EV_ANALOG, 2'd0, 8'h00, 1'b0, 1'b1)},
            // code above the limit, then an empty write
            '{8'h00, 0, none}, '{8'hFF, 0, none},
            '{8'h00, 0, none}, '{8'h01, 0, none}, '{8'h01, 0, none},
            '{8'h00, 0, none}, '{8'h00, 0, none},
            '{8'h02, 1, mk_event(rfr_pkg::EV_EMPTY, 2'd0, 8'h00, 1'b0, 1'b1)}
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i]) send_byte(rows[i].rx, rows[i].typed, rows[i].want);
        repeat (10) send_frame();
        drain();
        write_codes(8'hA5, 8'h10, 8'h20, 8'h21, 8'h30);
        repeat (10) send_frame();
        drain();
        write_codes(8'hFF, 8'h00, 8'hFF, 8'hFE, 8'hFF);
        repeat (10) send_frame();
        drain();
        // read and write share one code: read wins
        write_codes(8'h7E, 8'h03, 8'h03, 8'h04, 8'h04);
        repeat (10) send_frame();
        drain();
        write_codes(8'h00, 8'hFF, 8'h01, 8'h02, 8'hFF);
        repeat (10) send_frame();
        drain();
        write_codes(8'h55, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (5) send_frame();
        drain();
        write_codes(8'h3C, 8'h01, 8'h02, 8'h80, 8'h80);
        calm = 1'b1;
        repeat (10) send_frame();
        drain();
        if (errors == 0 && pending_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ request_frame_receiver.f @@
+incdir+hdl
hdl/rfr_pkg.sv
hdl/rfr_ram.sv
hdl/rfr_datapath.sv
hdl/rfr_ctrl.sv
hdl/request_frame_receiver.sv
hdl/rfr_checker.sv
verif/request_frame_receiver_tb.sv
